// ===== hdl/lsrd_pkg.sv =====
package lsrd_pkg;

  localparam int MaxRing = 16;
  localparam int CordicSteps = 16;
  localparam int DegUnit = 65536;
  localparam int OneQ14 = 16384;
  localparam int GainQ30 = 652032874;

  // Q2.14 sum of up to 19 unit vectors stays inside 20 bits signed.
  localparam int SumW = 20;
  // Vectoring datapath: sum scaled by 1024 plus CORDIC growth.
  localparam int VecW = 34;
  localparam int AngW = 26;
  localparam int SqW = 40;
  localparam int RootW = 20;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LOW = 2'd1;
  localparam logic [1:0] PH_MID = 2'd2;
  localparam logic [1:0] PH_HIGH = 2'd3;

  typedef struct packed {
    logic start;
    logic sel_mem;
  } cmd_t;

  typedef struct packed {
    logic done;
  } stat_t;

  function automatic logic [AngW-1:0] atan_val(input logic [3:0] k);
    logic [AngW-1:0] r;
    case (k)
      4'd0: r = 26'd2949120;
      4'd1: r = 26'd1740967;
      4'd2: r = 26'd919879;
      4'd3: r = 26'd466945;
      4'd4: r = 26'd234379;
      4'd5: r = 26'd117304;
      4'd6: r = 26'd58666;
      4'd7: r = 26'd29335;
      4'd8: r = 26'd14668;
      4'd9: r = 26'd7334;
      4'd10: r = 26'd3667;
      4'd11: r = 26'd1833;
      4'd12: r = 26'd917;
      4'd13: r = 26'd458;
      4'd14: r = 26'd229;
      default: r = 26'd115;
    endcase
    return r;
  endfunction

  function automatic longint sar64(input longint v, input int k);
    return v >>> k;
  endfunction

  // Unit vector of ring sensor i, worked out at elaboration.
  // step_q and step_r are the quotient and remainder of a full turn over n.
  function automatic longint unit_comp(input int i, input int n, input longint step_q,
                                       input longint step_r, input bit want_y);
    longint quarter, ang, t, r, x, y, z, xn, c, s, cx, sy;
    int quad;
    quarter = 64'd90 * DegUnit;
    ang = longint'(i) * step_q;
    t = longint'(i) * step_r + longint'(n >>> 1);
    while (t >= longint'(n)) begin
      t = t - longint'(n);
      ang = ang + 1;
    end
    quad = 0;
    r = ang;
    while (r >= quarter) begin
      r = r - quarter;
      quad = (quad + 1) & 3;
    end
    c = OneQ14;
    s = 0;
    if (r != 0) begin
      x = GainQ30;
      y = 0;
      z = r;
      for (int k = 0; k < CordicSteps; k++) begin
        if (z >= 0) begin
          xn = x - sar64(y, k); y = y + sar64(x, k); z = z - atan_val(4'(k));
        end else begin
          xn = x + sar64(y, k); y = y - sar64(x, k); z = z + atan_val(4'(k));
        end
        x = xn;
      end
      c = sar64(x + 32768, 16);
      s = sar64(y + 32768, 16);
    end
    case (quad)
      0: begin cx = c; sy = s; end
      1: begin cx = -s; sy = c; end
      2: begin cx = -c; sy = -s; end
      default: begin cx = s; sy = -c; end
    endcase
    return want_y ? sy : cx;
  endfunction

endpackage

// ===== hdl/lsrd_ctrl.sv =====
module lsrd_ctrl
  import lsrd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic frame_go,
  input  stat_t stat,
  output cmd_t cmd,
  output logic busy,
  output logic res_load
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LINE = 2'd1;
  localparam logic [1:0] S_MEM = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd.start = 1'b0;
    cmd.sel_mem = 1'b0;
    res_load = 1'b0;
    case (state)
      S_IDLE: if (frame_go) begin
        cmd.start = 1'b1;
        state_next = S_LINE;
      end
      S_LINE: if (stat.done) begin
        cmd.start = 1'b1;
        cmd.sel_mem = 1'b1;
        state_next = S_MEM;
      end
      S_MEM: begin
        cmd.sel_mem = 1'b1;
        if (stat.done) begin
          res_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// ===== hdl/lsrd_dp.sv =====
module lsrd_dp
  import lsrd_pkg::*;
#(
  parameter int RING_SENSORS = MaxRing
)(
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  logic [15:0] ring_cur,
  input  logic [15:0] ring_mem,
  input  logic [2:0] sides,
  output stat_t stat,
  output logic [9:0] ang_out,
  output logic [12:0] dist_out
);

  localparam int NUsed = (RING_SENSORS < 16) ? RING_SENSORS : 16;
  localparam longint FullTurn = 64'd360 * DegUnit;
  localparam longint AngStep = FullTurn / RING_SENSORS;
  localparam longint AngRem = FullTurn % RING_SENSORS;

  // pass: vector sum, squaring, 20 steps of cordic (16) and root (20), rounding
  logic [4:0] step;
  logic running;
  logic signed [SumW-1:0] sx, sy;
  logic [4:0] idx;
  logic signed [VecW-1:0] vx, vy;
  logic signed [AngW+1:0] vz;
  logic zero_vec;
  logic [SqW-1:0] rem, root_acc, sqbit;
  logic [1:0] ph;
  logic [15:0] ring;
  logic signed [SumW-1:0] ux, uy;

  localparam logic [1:0] P_SUM = 2'd0;
  localparam logic [1:0] P_SQ = 2'd1;
  localparam logic [1:0] P_ROT = 2'd2;
  localparam logic [1:0] P_FIN = 2'd3;

  logic signed [SqW-1:0] sq_mul;
  logic signed [SumW-1:0] sq_op;
  logic sq_half;

  always_comb begin
    ux = '0;
    uy = '0;
    for (int i = 0; i < 16; i++) begin
      if (i < NUsed && idx[3:0] == 4'(i)) begin
        ux = SumW'(unit_comp(i, RING_SENSORS, AngStep, AngRem, 1'b0));
        uy = SumW'(unit_comp(i, RING_SENSORS, AngStep, AngRem, 1'b1));
      end
    end
  end

  assign sq_op = sq_half ? sy : sx;
  assign sq_mul = SqW'(sq_op) * SqW'(sq_op);

  logic signed [AngW+1:0] zfix;
  logic [AngW+1:0] dround;
  logic [9:0] deg;
  logic [SqW-1:0] trial;
  logic [SqW-1:0] droot;

  always_comb begin
    zfix = (vz < 0) ? vz + (AngW+2)'(360 * DegUnit) : vz;
    dround = (AngW+2)'(zfix + (AngW+2)'(DegUnit / 2)) >> 16;
    deg = (dround[9:0] >= 10'd360) ? dround[9:0] - 10'd360 : dround[9:0];
    trial = root_acc + sqbit;
    droot = (root_acc + 40'd32) >> 6;
  end

  always_ff @(posedge clk) begin
    stat.done <= 1'b0;
    if (rst) begin
      running <= 1'b0;
    end else if (cmd.start) begin
      running <= 1'b1;
      ring <= cmd.sel_mem ? ring_mem : ring_cur;
      idx <= '0;
      ph <= P_SUM;
      sx <= '0;
      sy <= '0;
      sq_half <= 1'b0;
    end else if (running) begin
      case (ph)
        P_SUM: begin
          if (idx == 5'd16) begin
            sx <= sx - (sides[2] ? SumW'(OneQ14) : '0);
            sy <= sy + (sides[0] ? SumW'(OneQ14) : '0)
                     - (sides[1] ? SumW'(OneQ14) : '0);
            ph <= P_SQ;
            rem <= '0;
            sq_half <= 1'b0;
            idx <= '0;
          end else begin
            if (ring[idx[3:0]] && idx < 5'(NUsed)) begin
              sx <= sx + ux;
              sy <= sy + uy;
            end
            idx <= idx + 5'd1;
          end
        end
        P_SQ: begin
          rem <= rem + sq_mul;
          if (sq_half) begin
            ph <= P_ROT;
            zero_vec <= (sx == 0) && (sy == 0);
            if (sx < 0) begin
              vx <= -(VecW'(sx) <<< 10);
              vy <= -(VecW'(sy) <<< 10);
              vz <= (AngW+2)'(180 * DegUnit);
            end else begin
              vx <= VecW'(sx) <<< 10;
              vy <= VecW'(sy) <<< 10;
              vz <= '0;
            end
            step <= '0;
            root_acc <= '0;
            sqbit <= 40'd1 << 38;
          end
          sq_half <= 1'b1;
        end
        P_ROT: begin
          if (step < 5'd16) begin
            if (vy > 0) begin
              vx <= vx + (vy >>> step[3:0]);
              vy <= vy - (vx >>> step[3:0]);
              vz <= vz + (AngW+2)'(atan_val(step[3:0]));
            end else begin
              vx <= vx - (vy >>> step[3:0]);
              vy <= vy + (vx >>> step[3:0]);
              vz <= vz - (AngW+2)'(atan_val(step[3:0]));
            end
          end
          if (sqbit != 0) begin
            if (rem >= trial) begin
              rem <= rem - trial;
              root_acc <= (root_acc >> 1) + sqbit;
            end else begin
              root_acc <= root_acc >> 1;
            end
            sqbit <= sqbit >> 2;
          end
          step <= step + 5'd1;
          if (step >= 5'd19) ph <= P_FIN;
        end
        default: begin
          ang_out <= zero_vec ? 10'd0 : deg;
          if (!cmd.sel_mem)
            dist_out <= (droot > 40'd8191) ? 13'd8191 : droot[12:0];
          stat.done <= 1'b1;
          running <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== hdl/line_sensor_ring_direction.sv =====
// Line sensor ring direction finder.
// Input channel: rx_byte with in_valid / in_stall, one received byte per beat.
// A byte equal to frame_header starts a frame; the next three bytes form a
// 19-bit mask (ring bits 0-15, right, left, back).
// Config channel: cfg_valid / cfg_ready carrying cfg_data, the header byte.
// Output channel: out_valid / out_stall with detected, sensor_mask,
// line_angle, line_distance and memory_angle, one beat per frame.
// A frame with any mask bit set runs two passes of the shared unit
// (vector sum, squaring, 20 CORDIC and square root steps, rounding);
// in_stall holds the input until its result is loaded into the result
// register. An empty mask is answered without a pass of the unit.
// The result register lets the next frame start while a beat waits; a new
// high byte waits for the register to drain under out_stall.
// Reset clears the parser, remembered ring and header to zero, out_valid low.
module line_sensor_ring_direction
  import lsrd_pkg::*;
#(
  parameter int RING_SENSORS = MaxRing
)(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] rx_byte,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [7:0] cfg_data,
  output logic out_valid,
  input  logic out_stall,
  output logic detected,
  output logic [18:0] sensor_mask,
  output logic signed [9:0] line_angle,
  output logic [12:0] line_distance,
  output logic signed [9:0] memory_angle
);

  logic [7:0] frame_header;
  logic [1:0] parse_phase;
  logic [7:0] low_hold, mid_hold;
  logic [15:0] remembered, ring_cur, mem_next;
  logic [2:0] sides;
  logic [18:0] mask_new, mask_hold;
  logic busy, res_load, frame_go, acc;
  cmd_t cmd;
  stat_t stat;
  logic [9:0] ang_w;
  logic [12:0] dist_w;
  logic [9:0] line_ang_hold;
  logic [12:0] dist_hold;
  logic cmd_d;

  assign cfg_ready = 1'b1;
  assign in_stall = busy || cmd_d || (out_valid && out_stall && parse_phase == PH_HIGH);
  assign acc = in_valid && !in_stall;
  assign mask_new = {rx_byte[2:0], mid_hold, low_hold};
  assign frame_go = acc && parse_phase == PH_HIGH && mask_new != 0;
  assign mem_next = remembered | mask_new[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_header <= '0;
      parse_phase <= PH_HUNT;
      remembered <= '0;
      out_valid <= 1'b0;
      cmd_d <= 1'b0;
    end else begin
      cmd_d <= frame_go;
      if (cfg_valid) frame_header <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (acc) begin
        case (parse_phase)
          PH_HUNT: if (rx_byte == frame_header) parse_phase <= PH_LOW;
          PH_LOW: begin low_hold <= rx_byte; parse_phase <= PH_MID; end
          PH_MID: begin mid_hold <= rx_byte; parse_phase <= PH_HIGH; end
          default: begin
            parse_phase <= PH_HUNT;
            if (mask_new == 0) begin
              remembered <= '0;
              out_valid <= 1'b1;
              detected <= 1'b0;
              sensor_mask <= '0;
              line_angle <= -10'sd1;
              line_distance <= '0;
              memory_angle <= -10'sd1;
            end else begin
              ring_cur <= mask_new[15:0];
              sides <= mask_new[18:16];
              mask_hold <= mask_new;
              remembered <= mem_next;
            end
          end
        endcase
      end
      if (stat.done && !res_load) begin
        line_ang_hold <= ang_w;
        dist_hold <= dist_w;
      end
      if (res_load) begin
        out_valid <= 1'b1;
        detected <= 1'b1;
        sensor_mask <= mask_hold;
        line_angle <= line_ang_hold;
        line_distance <= dist_hold;
        memory_angle <= ang_w;
      end
    end
  end

  lsrd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .frame_go(cmd_d), .stat(stat), .cmd(cmd),
    .busy(busy), .res_load(res_load)
  );

  lsrd_dp #(.RING_SENSORS(RING_SENSORS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .ring_cur(ring_cur), .ring_mem(remembered),
    .sides(sides), .stat(stat), .ang_out(ang_w), .dist_out(dist_w)
  );

  a_stall_busy: assert property (@(posedge clk) disable iff (rst) busy |-> in_stall)
    else $error("input taken while unit busy");
  a_done_res: assert property (@(posedge clk) disable iff (rst)
    res_load |-> cmd.sel_mem)
    else $error("result loaded from line pass");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

// ===== tb/line_sensor_ring_direction_test.sv =====
`timescale 1ns / 100ps

module line_sensor_ring_direction_test
  import lsrd_pkg::*;
();

  localparam int LIMIT_CYCLES = 600000;
  localparam longint QUARTER_TURN = 90 * 65536;
  localparam longint ARCTAN [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  typedef struct {
    logic        det;
    logic [18:0] mask;
    logic signed [9:0] ang;
    logic [12:0] dist_q8;
    logic signed [9:0] mang;
  } frame_result_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [7:0] rx_byte = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [7:0] cfg_data = 0;
  logic out_valid;
  logic out_stall = 0;
  logic detected;
  logic [18:0] sensor_mask;
  logic signed [9:0] line_angle;
  logic [12:0] line_distance;
  logic signed [9:0] memory_angle;

  line_sensor_ring_direction dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .detected(detected), .sensor_mask(sensor_mask), .line_angle(line_angle),
    .line_distance(line_distance), .memory_angle(memory_angle)
  );

  logic [7:0] byte_queue [$];
  frame_result_t result_queue [$];
  longint ring_x [16];
  longint ring_y [16];
  logic [1:0] phase_st = PH_HUNT;
  logic [7:0] low_hold = 0, mid_hold = 0, header_val = 0;
  logic [15:0] ring_memory = 0;
  bit quiet = 0;
  bit hold_go = 0;
  int hold_cnt = 0;
  int errors = 0;
  int cycles = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void sensor_vec(input int i, output longint cx, output longint sy);
    longint ang, r, x, y, z, xn, c, s;
    int q;
    ang = (longint'(i) * 360 * 65536 + 8) / 16;
    q = int'((ang / QUARTER_TURN) % 4);
    r = ang % QUARTER_TURN;
    c = 16384;
    s = 0;
    if (r != 0) begin
      x = 652032874;
      y = 0;
      z = r;
      for (int k = 0; k < 16; k++) begin
        if (z >= 0) begin
          xn = x - (y >>> k); y = y + (x >>> k); z = z - ARCTAN[k];
        end else begin
          xn = x + (y >>> k); y = y - (x >>> k); z = z + ARCTAN[k];
        end
        x = xn;
      end
      c = (x + 32768) >>> 16;
      s = (y + 32768) >>> 16;
    end
    case (q)
      0: begin cx = c; sy = s; end
      1: begin cx = -s; sy = c; end
      2: begin cx = -c; sy = -s; end
      default: begin cx = s; sy = -c; end
    endcase
  endfunction

  function automatic void sum_vectors(input logic [15:0] ring, input logic [2:0] sides,
                                      output longint x, output longint y);
    x = 0;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (ring[i]) begin
        x += ring_x[i];
        y += ring_y[i];
      end
    end
    if (sides[0]) y += 16384;
    if (sides[1]) y -= 16384;
    if (sides[2]) x -= 16384;
  endfunction

  function automatic logic signed [9:0] heading_deg(input longint xi, input longint yi);
    longint x, y, z, xn, d;
    if (xi == 0 && yi == 0) return 10'sd0;
    x = xi * 1024;
    y = yi * 1024;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 180 * 65536;
    end
    for (int k = 0; k < 16; k++) begin
      if (y > 0) begin
        xn = x + (y >>> k); y = y - (x >>> k); z = z + ARCTAN[k];
      end else begin
        xn = x - (y >>> k); y = y + (x >>> k); z = z - ARCTAN[k];
      end
      x = xn;
    end
    if (z < 0) z += 360 * 65536;
    d = (z + 32768) / 65536;
    if (d >= 360) d -= 360;
    return 10'(d);
  endfunction

  function automatic longint floor_root(input longint v);
    longint res, b;
    res = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b); res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  task automatic track_byte(input logic [7:0] b);
    frame_result_t r;
    logic [18:0] m;
    longint x, y, d;
    case (phase_st)
      PH_HUNT: if (b == header_val) phase_st = PH_LOW;
      PH_LOW: begin low_hold = b; phase_st = PH_MID; end
      PH_MID: begin mid_hold = b; phase_st = PH_HIGH; end
      default: begin
        phase_st = PH_HUNT;
        m = {b[2:0], mid_hold, low_hold};
        if (m == 0) begin
          ring_memory = 0;
          r = '{1'b0, 19'd0, -10'sd1, 13'd0, -10'sd1};
        end else begin
          sum_vectors(m[15:0], m[18:16], x, y);
          r.det = 1;
          r.mask = m;
          r.ang = heading_deg(x, y);
          d = (floor_root(x * x + y * y) + 32) >>> 6;
          r.dist_q8 = d > 8191 ? 13'd8191 : 13'(d);
          ring_memory = ring_memory | m[15:0];
          sum_vectors(ring_memory, m[18:16], x, y);
          r.mang = heading_deg(x, y);
        end
        result_queue.push_back(r);
      end
    endcase
  endtask

  // driver: advance to the next byte only once the current beat is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) track_byte(rx_byte);
      if (!in_valid || !in_stall) begin
        if (byte_queue.size() > 0 && (quiet || $urandom_range(99) >= 6)) begin
          rx_byte <= byte_queue.pop_front();
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    frame_result_t e;
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected beat mask=%h", $time, sensor_mask);
          errors++;
        end else begin
          e = result_queue.pop_front();
          if (detected !== e.det || sensor_mask !== e.mask || line_angle !== e.ang ||
              line_distance !== e.dist_q8 || memory_angle !== e.mang) begin
            $display("%0t: expected det=%0d mask=%h ang=%0d dist=%0d mang=%0d", $time,
                     e.det, e.mask, e.ang, e.dist_q8, e.mang);
            $display("%0t: actual   det=%0d mask=%h ang=%0d dist=%0d mang=%0d", $time,
                     detected, sensor_mask, line_angle, line_distance, memory_angle);
            errors++;
          end
        end
      end
      if (hold_go && hold_cnt == 0) begin
        hold_go <= 0;
        hold_cnt <= 400;
        out_stall <= 1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= 1;
      end else begin
        out_stall <= !quiet && $urandom_range(99) < 6;
      end
    end
  end

  task automatic push_frame(input logic [7:0] lo, input logic [7:0] mi, input logic [7:0] hi);
    byte_queue.push_back(header_val);
    byte_queue.push_back(lo);
    byte_queue.push_back(mi);
    byte_queue.push_back(hi);
  endtask

  task automatic drain;
    while (byte_queue.size() > 0 || in_valid || result_queue.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_header(input logic [7:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    header_val = v;
  endtask

  task automatic random_bytes(input int count);
    logic [7:0] lo, mi, hi;
    int mode;
    while (count > 0) begin
      if ($urandom_range(9) == 0) begin
        byte_queue.push_back(8'($urandom));
        count -= 1;
      end else if ($urandom_range(19) == 0) begin
        push_frame(8'h00, 8'h00, {5'($urandom_range(31)), 3'b000});
        count -= 4;
      end else begin
        mode = $urandom_range(3);
        lo = 8'($urandom);
        mi = 8'($urandom);
        hi = 8'($urandom);
        if (mode == 0) begin
          lo = lo & 8'($urandom) & 8'($urandom);
          mi = mi & 8'($urandom) & 8'($urandom);
        end else if (mode == 1) begin
          {hi[2:0], mi, lo} = 19'(1) << $urandom_range(18);
        end
        push_frame(lo, mi, hi);
        count -= 4;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) sensor_vec(i, ring_x[i], ring_y[i]);
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_header(8'h00);
    byte_queue.push_back(8'h11);
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'h00);
    push_frame(8'hFF, 8'hFF, 8'hFF);
    push_frame(8'h01, 8'h01, 8'h00);
    push_frame(8'h00, 8'h00, 8'h03);
    push_frame(8'h10, 8'h00, 8'h04);
    push_frame(8'h01, 8'h00, 8'hF8);
    random_bytes(330);
    drain();

    write_header(8'hFF);
    random_bytes(360);
    drain();

    write_header(8'($urandom));
    quiet = 1;
    random_bytes(360);
    drain();
    quiet = 0;

    write_header(8'h5A);
    hold_go = 1;
    random_bytes(360);
    drain();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== line_sensor_ring_direction.f =====
hdl/lsrd_pkg.sv
hdl/lsrd_ctrl.sv
hdl/lsrd_dp.sv
hdl/line_sensor_ring_direction.sv
tb/line_sensor_ring_direction_test.sv
